// ----- rtl/core/spn8_pkg.sv -----
`default_nettype none

package spn8_pkg;

  localparam int unsigned BlockBits  = 8;
  localparam int unsigned NibbleBits = 4;
  localparam int unsigned KeyBits    = 24;
  localparam int unsigned RoundCount = 4;
  localparam int unsigned SboxBits   = 64;
  localparam int unsigned PermBits   = 24;
  localparam int unsigned PermIdxBits = 3;
  localparam int unsigned DataBits   = 64;
  localparam int unsigned AddrBits   = 6;
  localparam int unsigned QueueDepthDefault = 2;

  localparam logic [SboxBits-1:0] SboxReset = 64'hFEDC_BA98_7654_3210;
  localparam logic [PermBits-1:0] PermReset = 24'd16434824;

  typedef enum logic [2:0] {
    RegKey     = 3'd0,
    RegSbox    = 3'd1,
    RegInvSbox = 3'd2,
    RegPerm    = 3'd3,
    RegInvPerm = 3'd4
  } spn8_reg_t;

  typedef struct packed {
    logic                 decrypt;
    logic [BlockBits-1:0] block;
  } spn8_item_t;

  typedef struct packed {
    logic [KeyBits-1:0]  key;
    logic [SboxBits-1:0] sbox;
    logic [SboxBits-1:0] inv_sbox;
    logic [PermBits-1:0] perm;
    logic [PermBits-1:0] inv_perm;
  } spn8_cfg_t;

  // Round key r (1..5) is the byte starting at key bit index 4(r-1), MSB first.
  function automatic logic [BlockBits-1:0] round_key(input logic [KeyBits-1:0] key,
                                                     input int unsigned r);
    int unsigned base;
    base = KeyBits - BlockBits - NibbleBits * (r - 1);
    return key[base +: BlockBits];
  endfunction

  function automatic logic [BlockBits-1:0] subst(input logic [BlockBits-1:0] b,
                                                 input logic [SboxBits-1:0] tbl);
    logic [NibbleBits-1:0] hi;
    logic [NibbleBits-1:0] lo;
    hi = b[BlockBits-1:NibbleBits];
    lo = b[NibbleBits-1:0];
    return {tbl[NibbleBits*hi +: NibbleBits], tbl[NibbleBits*lo +: NibbleBits]};
  endfunction

  // Output bit index i (index 0 is the MSB) takes input bit index tbl entry i.
  function automatic logic [BlockBits-1:0] permute(input logic [BlockBits-1:0] b,
                                                   input logic [PermBits-1:0] tbl);
    logic [BlockBits-1:0]   res;
    logic [PermIdxBits-1:0] src;
    res = '0;
    for (int unsigned i = 0; i < BlockBits; i++) begin
      src = tbl[PermIdxBits*i +: PermIdxBits];
      res[BlockBits-1-i] = b[(BlockBits-1) - src];
    end
    return res;
  endfunction

  // One round stage j (1..RoundCount) after the initial key mix.
  function automatic logic [BlockBits-1:0] round_apply(input spn8_item_t it,
                                                       input spn8_cfg_t cfg,
                                                       input int unsigned j);
    logic [BlockBits-1:0] b;
    int unsigned          r;
    b = it.block;
    if (!it.decrypt) begin
      b = subst(b, cfg.sbox);
      if (j < RoundCount) begin
        b = permute(b, cfg.perm);
      end
      b = b ^ round_key(cfg.key, j + 1);
    end else begin
      r = RoundCount + 1 - j;
      if (r < RoundCount) begin
        b = permute(b, cfg.inv_perm);
      end
      b = subst(b, cfg.inv_sbox);
      b = b ^ round_key(cfg.key, r);
    end
    return b;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/spn_block_cipher_8bit_top.sv -----
`default_nettype none

// Four-round 8-bit substitution-permutation cipher.
//
// Input channel: in_valid/in_stall carry one request of in_mode (0 encrypt,
// 1 decrypt) and in_block_in. A request is taken on a rising edge with
// in_valid high and in_stall low. Results leave on out_valid/out_stall with
// out_block_out, one result per request, in request order.
//
// Throughput: one request per cycle while out_stall stays low. A request
// passes through the front register, one queue slot and four round stages;
// the last stage is the output register.
//
// When the receiver stalls, the round pipeline holds, bubbles close up, the
// queue fills and only then does in_stall rise. Reset (rst_n low, synchronous)
// drops all in-flight requests and loads key 0 and identity S-box and
// permutation tables.
//
// Configuration: APB-style, 64-bit data, register i at byte address 8*i.
// Write only while the block holds no requests.
module spn_block_cipher_8bit_top import spn8_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // request channel
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 in_mode,
  input  wire logic [BlockBits-1:0] in_block_in,
  // result channel
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [BlockBits-1:0]      out_block_out,
  // register port
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [AddrBits-1:0]  paddr,
  input  wire logic [DataBits-1:0]  pwdata,
  output logic [DataBits-1:0]       prdata,
  output logic                      pready
);

  spn8_cfg_t  cfg_r;
  logic       cfg_wr;
  logic [2:0] reg_idx;

  logic       q_push_valid, q_push_ready;
  spn8_item_t q_push_item;
  logic       q_pop_valid, q_pop_ready;
  spn8_item_t q_pop_item;

  // Registers sit on 8-byte boundaries; the low address bits are ignored.
  assign reg_idx = paddr[AddrBits-1:3];
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;

  // Write decode: drop writes beyond the register list, mask narrow registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.key      <= '0;
      cfg_r.sbox     <= SboxReset;
      cfg_r.inv_sbox <= SboxReset;
      cfg_r.perm     <= PermReset;
      cfg_r.inv_perm <= PermReset;
    end else if (cfg_wr) begin
      case (reg_idx)
        RegKey:     cfg_r.key      <= pwdata[KeyBits-1:0];
        RegSbox:    cfg_r.sbox     <= pwdata;
        RegInvSbox: cfg_r.inv_sbox <= pwdata;
        RegPerm:    cfg_r.perm     <= pwdata[PermBits-1:0];
        RegInvPerm: cfg_r.inv_perm <= pwdata[PermBits-1:0];
        default: ;
      endcase
    end
  end

  // Read back, zero-extended.
  always_comb begin
    case (reg_idx)
      RegKey:     prdata = DataBits'(cfg_r.key);
      RegSbox:    prdata = cfg_r.sbox;
      RegInvSbox: prdata = cfg_r.inv_sbox;
      RegPerm:    prdata = DataBits'(cfg_r.perm);
      RegInvPerm: prdata = DataBits'(cfg_r.inv_perm);
      default:    prdata = '0;
    endcase
  end

  // Front: take the request, decode mode, apply the opening key mix.
  spn8_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_mode     (in_mode),
    .in_block_in (in_block_in),
    .key         (cfg_r.key),
    .push_valid  (q_push_valid),
    .push_ready  (q_push_ready),
    .push_item   (q_push_item)
  );

  // Queue decouples front stalls from back-end stalls.
  spn8_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_item  (q_push_item),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_item   (q_pop_item)
  );

  // Back: one register stage per round, elastic per-stage handshake.
  spn8_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .pop_valid     (q_pop_valid),
    .pop_ready     (q_pop_ready),
    .pop_item      (q_pop_item),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_block_out (out_block_out)
  );

endmodule

`default_nettype wire

// ----- rtl/core/spn8_front.sv -----
`default_nettype none

module spn8_front import spn8_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 in_mode,
  input  wire logic [BlockBits-1:0] in_block_in,
  input  wire logic [KeyBits-1:0]   key,
  output logic                      push_valid,
  input  wire logic                 push_ready,
  output spn8_item_t                push_item
);

  logic       f_valid_r, f_valid_nxt;
  spn8_item_t f_item_r;
  logic       accept;
  logic       push;

  assign in_stall   = f_valid_r && !push_ready;
  assign accept     = in_valid && !in_stall;
  assign push       = f_valid_r && push_ready;
  assign push_valid = f_valid_r;
  assign push_item  = f_item_r;

  always_comb begin
    f_valid_nxt = f_valid_r;
    if (accept) begin
      f_valid_nxt = 1'b1;
    end else if (push) begin
      f_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else begin
      f_valid_r <= f_valid_nxt;
    end
  end

  // Decode mode and apply the opening key mix: key 1 encrypting, key 5 decrypting.
  always_ff @(posedge clk) begin
    if (accept) begin
      f_item_r.decrypt <= in_mode;
      f_item_r.block   <= in_block_in ^
                          (in_mode ? round_key(key, RoundCount + 1) : round_key(key, 1));
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/spn8_queue.sv -----
`default_nettype none

module spn8_queue import spn8_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDefault
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push_valid,
  output logic      push_ready,
  input  wire spn8_item_t push_item,
  output logic      pop_valid,
  input  wire logic pop_ready,
  output spn8_item_t pop_item
);

  localparam int unsigned PtrBits = $clog2(Depth);
  localparam int unsigned CntBits = $clog2(Depth + 1);
  localparam logic [PtrBits-1:0] LastPtr = PtrBits'(Depth - 1);
  localparam logic [CntBits-1:0] FullCnt = CntBits'(Depth);

  spn8_item_t         mem_r [Depth];
  logic [PtrBits-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrBits-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntBits-1:0] cnt_r, cnt_nxt;
  logic               push, pop;

  assign push_ready = (cnt_r != FullCnt);
  assign pop_valid  = (cnt_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/spn8_back.sv -----
`default_nettype none

module spn8_back import spn8_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire spn8_cfg_t            cfg,
  input  wire logic                 pop_valid,
  output logic                      pop_ready,
  input  wire spn8_item_t           pop_item,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [BlockBits-1:0]      out_block_out
);

  logic [RoundCount-1:0] v_r;
  logic [RoundCount-1:0] v_in;
  logic [RoundCount-1:0] rdy;
  spn8_item_t            d_r  [RoundCount];
  spn8_item_t            d_in [RoundCount];

  assign pop_ready     = rdy[0];
  assign out_valid     = v_r[RoundCount-1];
  assign out_block_out = d_r[RoundCount-1].block;

  for (genvar j = 0; j < RoundCount; j++) begin : g_stage
    if (j == 0) begin : g_head
      assign v_in[j] = pop_valid;
      assign d_in[j] = pop_item;
    end else begin : g_body
      assign v_in[j] = v_r[j-1];
      assign d_in[j] = d_r[j-1];
    end

    if (j == RoundCount - 1) begin : g_last
      assign rdy[j] = !v_r[j] || !out_stall;
    end else begin : g_mid
      assign rdy[j] = !v_r[j] || rdy[j+1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (rdy[j]) begin
        v_r[j] <= v_in[j];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[j] && v_in[j]) begin
        d_r[j].decrypt <= d_in[j].decrypt;
        d_r[j].block   <= round_apply(d_in[j], cfg, j + 1);
      end
    end
  end

endmodule

`default_nettype wire
